>>> hw/rtl/sicn_pkg.sv
// Package for the spin isometry compose and normalise block: types, constants and helpers.
package sicn_pkg;

    localparam int FRAC_BITS = 24;
    localparam int WORD_BITS = 32;
    localparam int EFF_BITS  = (WORD_BITS < 32) ? WORD_BITS : 32;

    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int LEN_W  = SUM_W - FRAC_BITS;
    localparam int K_W    = FRAC_BITS + 3;
    localparam int SCL_W  = DATA_W + K_W;

    localparam int ADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [ADDR_W-1:0] ADDR_GEOMETRY = ADDR_W'(0);

    typedef enum logic [1:0] {
        GEO_SPHERICAL  = 2'd0,
        GEO_EUCLIDEAN  = 2'd1,
        GEO_HYPERBOLIC = 2'd2
    } geo_mode_t;

    // Window limits on the rounded length: LO < len < HI, with LO rounded down and HI rounded up in integers
    localparam longint WIN_LO = (longint'(99) << FRAC_BITS) / 100;
    localparam longint WIN_HI = ((longint'(101) << FRAC_BITS) + 99) / 100;

    localparam logic signed [SUM_W-1:0] HALF_LSB  = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] HALF_OUT  = SUM_W'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] SAT_HI    = (SUM_W'(1) << (EFF_BITS - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO    = -SAT_HI - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] ONE_WIDE  = SUM_W'(1) << FRAC_BITS;
    localparam logic signed [K_W-1:0]   THREE_FIX = K_W'(3) << FRAC_BITS;

    typedef struct packed {
        logic signed [DATA_W-1:0] first_a;
        logic signed [DATA_W-1:0] first_b;
        logic signed [DATA_W-1:0] first_c;
        logic signed [DATA_W-1:0] first_d;
        logic signed [DATA_W-1:0] second_a;
        logic signed [DATA_W-1:0] second_b;
        logic signed [DATA_W-1:0] second_c;
        logic signed [DATA_W-1:0] second_d;
    } sicn_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_a;
        logic signed [DATA_W-1:0] out_b;
        logic signed [DATA_W-1:0] out_c;
        logic signed [DATA_W-1:0] out_d;
        logic                     identity_fallback;
    } sicn_out_t;

    // Multiply by the geometry sign: +1, 0 or -1
    function automatic logic signed [SUM_W-1:0] scale_g(input logic signed [SUM_W-1:0] x,
                                                        input logic [1:0] mode);
        logic signed [SUM_W-1:0] r;
        unique case (mode)
            GEO_SPHERICAL:  r = x;
            GEO_HYPERBOLIC: r = -x;
            default:        r = '0;
        endcase
        return r;
    endfunction

    // Clamp to the signed effective word range
    function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [SUM_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > SAT_HI) begin
            r = DATA_W'(SAT_HI);
        end else if (x < SAT_LO) begin
            r = DATA_W'(SAT_LO);
        end else begin
            r = DATA_W'(x);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/spin_isometry_compose_normalize.sv
// Top level: pipelined spin-group product with first-order renormalisation.
// Throughput: one request per cycle while m_ready is high; a full stage holds while the stage after it holds.
// A request is accepted while a result waits at the output as long as any stage is empty.
// Reset (aresetn low at a clock edge) drops every request in flight and sets geometry to 0.
// Products and length squares are 32x32 multipliers, one register stage each.
module spin_isometry_compose_normalize (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sicn_pkg::sicn_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sicn_pkg::sicn_out_t             m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sicn_pkg::ADDR_W-1:0]     paddr,
    input  logic [sicn_pkg::PDATA_W-1:0]    pwdata,
    output logic [sicn_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import sicn_pkg::*;

    localparam int NSTG = 9;

    // ---------------- configuration ----------------
    logic [1:0] geometry_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geometry_reg <= GEO_SPHERICAL;
        end else if (psel && penable && pwrite && (paddr == ADDR_GEOMETRY)) begin
            geometry_reg <= pwdata[1:0];
        end
    end

    assign prdata = (paddr == ADDR_GEOMETRY) ? PDATA_W'(geometry_reg) : '0;

    // ---------------- flow control ----------------
    // A stage loads when it is empty or when the stage after it loads too.
    logic [NSTG:1] v_reg;
    logic [NSTG:1] ld;

    always_comb begin
        ld[NSTG] = !v_reg[NSTG] || m_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign s_ready = ld[1];
    assign m_valid = v_reg[NSTG];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[1]) begin
                v_reg[1] <= s_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (ld[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: the sixteen partial products ----------------
    // prod[comp][term]; the term order matches the sign pattern used in stage 2
    logic signed [PROD_W-1:0] prod_reg [4][4];

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            prod_reg[0][0] <= s_data.first_a * s_data.second_a;
            prod_reg[0][1] <= s_data.first_b * s_data.second_b;
            prod_reg[0][2] <= s_data.first_c * s_data.second_c;
            prod_reg[0][3] <= s_data.first_d * s_data.second_d;
            prod_reg[1][0] <= s_data.first_a * s_data.second_b;
            prod_reg[1][1] <= s_data.first_b * s_data.second_a;
            prod_reg[1][2] <= s_data.first_c * s_data.second_d;
            prod_reg[1][3] <= s_data.first_d * s_data.second_c;
            prod_reg[2][0] <= s_data.first_a * s_data.second_c;
            prod_reg[2][1] <= s_data.first_b * s_data.second_d;
            prod_reg[2][2] <= s_data.first_c * s_data.second_a;
            prod_reg[2][3] <= s_data.first_d * s_data.second_b;
            prod_reg[3][0] <= s_data.first_a * s_data.second_d;
            prod_reg[3][1] <= s_data.first_b * s_data.second_c;
            prod_reg[3][2] <= s_data.first_c * s_data.second_b;
            prod_reg[3][3] <= s_data.first_d * s_data.second_a;
        end
    end

    // ---------------- stage 2: signed pair sums ----------------
    logic signed [SUM_W-1:0] t [4][4];
    logic signed [SUM_W-1:0] half_next [4][2];
    logic signed [SUM_W-1:0] half_reg  [4][2];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                t[c][j] = SUM_W'(prod_reg[c][j]);
            end
        end
        // A = aa' - bb' - g(cc' + dd')
        half_next[0][0] = t[0][0] - t[0][1];
        half_next[0][1] = -scale_g(t[0][2] + t[0][3], geometry_reg);
        // B = ab' + ba' + g(cd' - dc')
        half_next[1][0] = t[1][0] + t[1][1];
        half_next[1][1] = scale_g(t[1][2] - t[1][3], geometry_reg);
        // C = ac' - bd' + ca' + db'
        half_next[2][0] = t[2][0] - t[2][1];
        half_next[2][1] = t[2][2] + t[2][3];
        // D = ad' + bc' - cb' + da'
        half_next[3][0] = t[3][0] + t[3][1];
        half_next[3][1] = t[3][3] - t[3][2];
    end

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            half_reg <= half_next;
        end
    end

    // ---------------- stage 3: final sum, round half up, saturate ----------------
    logic signed [SUM_W-1:0]  comp_sum [4];
    logic signed [DATA_W-1:0] p_next   [4];
    logic signed [DATA_W-1:0] p3_reg   [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            comp_sum[c] = (half_reg[c][0] + half_reg[c][1] + HALF_LSB) >>> FRAC_BITS;
            p_next[c]   = sat_word(comp_sum[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            p3_reg <= p_next;
        end
    end

    // ---------------- stage 4: squares of the saturated components ----------------
    logic signed [PROD_W-1:0] sq_reg [4];
    logic signed [DATA_W-1:0] p4_reg [4];

    always_ff @(posedge aclk) begin
        if (ld[4]) begin
            for (int c = 0; c < 4; c++) begin
                sq_reg[c] <= p3_reg[c] * p3_reg[c];
            end
            p4_reg <= p3_reg;
        end
    end

    // ---------------- stage 5: length pair sums, g on c and d ----------------
    logic signed [SUM_W-1:0]  lhalf_reg [2];
    logic signed [DATA_W-1:0] p5_reg    [4];

    always_ff @(posedge aclk) begin
        if (ld[5]) begin
            lhalf_reg[0] <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]);
            lhalf_reg[1] <= scale_g(SUM_W'(sq_reg[2]) + SUM_W'(sq_reg[3]), geometry_reg);
            p5_reg       <= p4_reg;
        end
    end

    // ---------------- stage 6: rounded length, not saturated ----------------
    logic signed [SUM_W-1:0] len_wide;
    logic signed [LEN_W-1:0] len_reg;
    logic signed [DATA_W-1:0] p6_reg [4];

    assign len_wide = (lhalf_reg[0] + lhalf_reg[1] + HALF_LSB) >>> FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (ld[6]) begin
            len_reg <= len_wide[LEN_W-1:0];
            p6_reg  <= p5_reg;
        end
    end

    // ---------------- stage 7: window test and scale factor ----------------
    // Inside the window k = 3 - len lies near 2.0 and fits K_W bits.
    logic                     in_win;
    logic signed [K_W-1:0]    k_reg;
    logic                     fb7_reg;
    logic signed [DATA_W-1:0] p7_reg [4];

    assign in_win = (len_reg > LEN_W'(WIN_LO)) && (len_reg < LEN_W'(WIN_HI));

    always_ff @(posedge aclk) begin
        if (ld[7]) begin
            k_reg   <= THREE_FIX - len_reg[K_W-1:0];
            fb7_reg <= !in_win;
            p7_reg  <= p6_reg;
        end
    end

    // ---------------- stage 8: component times factor ----------------
    logic signed [SCL_W-1:0] scl_reg [4];
    logic                    fb8_reg;

    always_ff @(posedge aclk) begin
        if (ld[8]) begin
            for (int c = 0; c < 4; c++) begin
                scl_reg[c] <= p7_reg[c] * k_reg;
            end
            fb8_reg <= fb7_reg;
        end
    end

    // ---------------- stage 9: round, saturate, identity fallback ----------------
    logic signed [DATA_W-1:0] r [4];
    sicn_out_t                out_next;
    sicn_out_t                out_reg;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            r[c] = sat_word((SUM_W'(scl_reg[c]) + HALF_OUT) >>> (FRAC_BITS + 1));
        end
        if (fb8_reg) begin
            out_next.out_a = sat_word(ONE_WIDE);
            out_next.out_b = '0;
            out_next.out_c = '0;
            out_next.out_d = '0;
        end else begin
            out_next.out_a = r[0];
            out_next.out_b = r[1];
            out_next.out_c = r[2];
            out_next.out_d = r[3];
        end
        out_next.identity_fallback = fb8_reg;
    end

    always_ff @(posedge aclk) begin
        if (ld[9]) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule
